/* rtl/emgb_pkg.sv */
// ----------------------------------------------------------------------------
// emgb_pkg
// Shared types, constants and decode helpers for the emulated memory/GPIO bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emgb_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;
    localparam logic [31:0] GPIO_BASE_DEF = 32'd538968064;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LANES   = 4;

    // GPIO register offsets from the window base
    localparam logic [31:0] OFS_FSEL_LOW  = 32'h00;
    localparam logic [31:0] OFS_FSEL_MID  = 32'h04;
    localparam logic [31:0] OFS_FSEL_HIGH = 32'h08;
    localparam logic [31:0] OFS_PIN_SET   = 32'h1C;
    localparam logic [31:0] OFS_PIN_CLEAR = 32'h28;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BAD_PHYS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        GR_NONE      = 3'd0,
        GR_FSEL_LOW  = 3'd1,
        GR_FSEL_MID  = 3'd2,
        GR_FSEL_HIGH = 3'd3,
        GR_PIN_SET   = 3'd4,
        GR_PIN_CLEAR = 3'd5
    } t_gpio_reg;

    // where the read data of a result comes from
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_MEM  = 2'd1,
        RD_ADDR = 2'd2
    } t_rd_src;

    typedef struct packed {
        logic        we;
        t_gpio_reg   sel;
        logic [31:0] data;
    } t_gpio_req;

    function automatic t_gpio_reg gpio_decode(input logic [31:0] offset);
        t_gpio_reg sel;
        priority if (offset == OFS_FSEL_LOW)  sel = GR_FSEL_LOW;
        else if (offset == OFS_FSEL_MID)      sel = GR_FSEL_MID;
        else if (offset == OFS_FSEL_HIGH)     sel = GR_FSEL_HIGH;
        else if (offset == OFS_PIN_SET)       sel = GR_PIN_SET;
        else if (offset == OFS_PIN_CLEAR)     sel = GR_PIN_CLEAR;
        else                                  sel = GR_NONE;
        return sel;
    endfunction

endpackage

`default_nettype wire

/* rtl/emulated_memory_gpio_bus.sv */
// ----------------------------------------------------------------------------
// emulated_memory_gpio_bus
// Word bus: byte memory below GPIO_BASE, GPIO register window above it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one access per item: s_axis_tuser is the kind (0 read,
//   1 write), s_axis_tdata carries address and write data. Master side gives
//   one result per item: read data, status and the pin levels after it.
//   The result passes the middle stage (the synchronous lane RAM read) and
//   then the output register before it shows on m_axis. Throughput: one
//   item per cycle while m_axis does not stall; the byte RAMs have one port
//   per lane and each item uses it once, writes landing before the next
//   item's read.
//   Reset clears the GPIO registers and the handshake state; memory content
//   is not cleared and must be written before it is read.
//   When the receiver stalls, the output register holds the result, the
//   middle stage fills, and then s_axis_tready drops until m_axis moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emulated_memory_gpio_bus #(
    parameter int unsigned MEM_BYTES = emgb_pkg::MEM_BYTES_DEF,
    parameter logic [31:0] GPIO_BASE = emgb_pkg::GPIO_BASE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // address[31:0], write_data[63:32]
    input  wire logic [0:0]  s_axis_tuser,   // op[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // read_data[31:0], status[33:32],
                                             // pin_levels[65:34], zero above
);
    import emgb_pkg::*;

    localparam int unsigned DEPTH = (MEM_BYTES + 3) / 4;
    localparam int unsigned ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic        w_op;
    logic [31:0] w_addr, w_wdata, w_ofs;
    logic        w_accept, w_s1_adv;
    logic        w_is_mem, w_fits;
    t_gpio_reg   w_sel;
    t_status     w_status;
    t_rd_src     w_src;
    t_gpio_req   w_greq;
    logic [31:0] w_pins_next, w_pins, w_mem_rdata, w_rdata;

    logic        r_s1_valid;
    t_status     r_s1_status;
    t_rd_src     r_s1_src;
    logic [31:0] r_s1_addr, r_s1_pins;

    logic        r_out_valid;
    logic [31:0] r_out_rdata, r_out_pins;
    t_status     r_out_status;

    assign w_op    = s_axis_tuser[0];
    assign w_addr  = s_axis_tdata[31:0];
    assign w_wdata = s_axis_tdata[63:32];

    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // decode
    assign w_is_mem = w_addr < GPIO_BASE;
    assign w_fits   = ({1'b0, w_addr} + 33'd4) <= 33'(MEM_BYTES);
    assign w_ofs    = w_addr - GPIO_BASE;
    assign w_sel    = gpio_decode(w_ofs);

    always_comb begin
        w_status = ST_OK;
        w_src    = RD_ZERO;
        if (w_is_mem) begin
            if (!w_fits) begin
                w_status = ST_RANGE;
            end else if (!w_op) begin
                w_src = RD_MEM;
            end
        end else if (w_op) begin
            if (w_sel == GR_NONE) begin
                w_status = ST_BAD_PHYS;
            end
        end else if (w_sel == GR_FSEL_LOW || w_sel == GR_FSEL_MID ||
                     w_sel == GR_FSEL_HIGH) begin
            w_src = RD_ADDR;
        end else begin
            w_status = ST_BAD_PHYS;
        end
    end

    assign w_greq.we   = w_accept && !w_is_mem && w_op;
    assign w_greq.sel  = w_sel;
    assign w_greq.data = w_wdata;

    emgb_gpio u_gpio (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_greq),
        .o_pins_next (w_pins_next),
        .o_pins      (w_pins)
    );

    emgb_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (w_accept && w_src == RD_MEM),
        .i_we    (w_accept && w_is_mem && w_fits && w_op),
        .i_row   (w_addr[ROW_W+1:2]),
        .i_ofs   (w_addr[1:0]),
        .i_wdata (w_wdata),
        .o_rdata (w_mem_rdata)
    );

    // middle stage: waits for the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_src    <= w_src;
            r_s1_addr   <= w_addr;
            r_s1_pins   <= w_pins_next;
        end
    end

    always_comb begin
        unique case (r_s1_src)
            RD_MEM:  w_rdata = w_mem_rdata;
            RD_ADDR: w_rdata = r_s1_addr;
            default: w_rdata = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_rdata  <= w_rdata;
            r_out_status <= r_s1_status;
            r_out_pins   <= r_s1_pins;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_pins, r_out_status, r_out_rdata};

    // flagged accesses never return data
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_rdata == '0)
        else $error("flagged result carries read data");

    // tready only drops with both stages full and the sink stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without back-pressure");

    // pin levels only change when an item is taken
    a_pins_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_pins))
        else $error("pin levels changed with no item");

    // pin levels captured with an item are the register state in the next cycle
    a_pins_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_pins == w_pins)
        else $error("captured pin levels differ from register");

    // status code never reserved value
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_status == ST_OK || r_out_status == ST_RANGE ||
                        r_out_status == ST_BAD_PHYS)
        else $error("reserved status code");

endmodule

`default_nettype wire

/* rtl/emgb_mem.sv */
// ----------------------------------------------------------------------------
// emgb_mem
// Byte memory as four byte-lane synchronous RAMs; unaligned little-endian
// word read/write, one access per cycle, read data registered and valid in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emgb_mem #(
    parameter int unsigned MEM_BYTES = emgb_pkg::MEM_BYTES_DEF,
    localparam int unsigned DEPTH    = (MEM_BYTES + 3) / 4,
    localparam int unsigned ROW_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_re,
    input  wire logic             i_we,
    input  wire logic [ROW_W-1:0] i_row,     // address / 4
    input  wire logic [1:0]       i_ofs,     // address % 4
    input  wire logic [31:0]      i_wdata,
    output logic      [31:0]      o_rdata
);
    import emgb_pkg::*;

    logic [7:0] w_lane_rd [LANES];
    logic [1:0] r_ofs;

    for (genvar L = 0; L < LANES; L++) begin : g_lane
        logic [7:0]       mem [DEPTH];
        logic [7:0]       r_rd;
        logic [ROW_W-1:0] w_row;
        logic [1:0]       w_j;

        // lanes below the start offset hold bytes of the next row
        assign w_row = (2'(L) < i_ofs) ? ROW_W'(i_row + 1'b1) : i_row;
        assign w_j   = 2'(2'(L) - i_ofs);

        always_ff @(posedge i_clk) begin
            if (i_we) begin
                mem[w_row] <= i_wdata[8*w_j +: 8];
            end
            if (i_re) begin
                r_rd <= mem[w_row];
            end
        end
        assign w_lane_rd[L] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_ofs <= i_ofs;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_rdata[8*k +: 8] = w_lane_rd[2'(r_ofs + 2'(k))];
        end
    end

endmodule

`default_nettype wire

/* rtl/emgb_gpio.sv */
// ----------------------------------------------------------------------------
// emgb_gpio
// GPIO function select and pin level registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emgb_gpio (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire emgb_pkg::t_gpio_req i_req,
    output logic [31:0]              o_pins_next,   // levels after this request
    output logic [31:0]              o_pins
);
    import emgb_pkg::*;

    logic [31:0] r_fsel_low, r_fsel_mid, r_fsel_high, r_pins;
    logic [31:0] n_fsel_low, n_fsel_mid, n_fsel_high, n_pins;

    always_comb begin
        n_fsel_low  = r_fsel_low;
        n_fsel_mid  = r_fsel_mid;
        n_fsel_high = r_fsel_high;
        n_pins      = r_pins;
        if (i_req.we) begin
            unique case (i_req.sel)
                GR_FSEL_LOW:  n_fsel_low = i_req.data;
                GR_FSEL_MID:  n_fsel_mid = i_req.data;
                GR_FSEL_HIGH: begin
                    // zero to the high register wipes all three
                    if (i_req.data == '0) begin
                        n_fsel_low = '0;
                        n_fsel_mid = '0;
                    end
                    n_fsel_high = i_req.data;
                end
                GR_PIN_SET:   n_pins = r_pins | i_req.data;
                GR_PIN_CLEAR: n_pins = r_pins & ~i_req.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel_low  <= '0;
            r_fsel_mid  <= '0;
            r_fsel_high <= '0;
            r_pins      <= '0;
        end else begin
            r_fsel_low  <= n_fsel_low;
            r_fsel_mid  <= n_fsel_mid;
            r_fsel_high <= n_fsel_high;
            r_pins      <= n_pins;
        end
    end

    assign o_pins_next = n_pins;
    assign o_pins      = r_pins;

endmodule

`default_nettype wire
